@@ sv/sidc_pkg.sv @@
package sidc_pkg;

    localparam int DEF_DATA_WIDTH = 32;

    localparam logic [63:0] DIV_ZERO_VALUE = 64'd80085;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_DIV_ZERO = 2'd1,
        STAT_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic special;
        logic last_step;
    } dp_stat_t;

endpackage

@@ sv/sidc_ctrl.sv @@
module sidc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output sidc_pkg::dp_cmd_t  cmd,
    input  sidc_pkg::dp_stat_t stat
);
    import sidc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.special ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/sidc_datapath.sv @@
module sidc_datapath #(
    parameter int DATA_WIDTH = sidc_pkg::DEF_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sidc_pkg::dp_cmd_t            cmd,
    output sidc_pkg::dp_stat_t           stat,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output sidc_pkg::status_t            status
);
    import sidc_pkg::*;

    localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    logic [DATA_WIDTH-1:0] a_u;
    logic [DATA_WIDTH-1:0] b_u;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    logic                  div_zero;
    logic                  overflow;

    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] num_next;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic                  neg_reg;
    status_t               code_reg;
    logic [CW-1:0]         count_reg;

    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH+1:0] diff;
    logic                  borrow;
    logic [DATA_WIDTH-1:0] result;

    logic signed [DATA_WIDTH-1:0] quotient_reg;
    status_t                      status_reg;

    assign a_u      = dividend;
    assign b_u      = divisor;
    assign a_mag    = a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
    assign b_mag    = b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;
    assign div_zero = (b_u == '0);
    assign overflow = (a_u == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (b_u == '1);

    assign stat.special   = div_zero || overflow;
    assign stat.last_step = (count_reg == CW'(DATA_WIDTH - 1));

    assign rem_shift = {rem_reg, num_reg[DATA_WIDTH-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign borrow    = diff[DATA_WIDTH+1];
    assign rem_next  = borrow ? rem_shift[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
    assign num_next  = {num_reg[DATA_WIDTH-2:0], ~borrow};
    assign result    = neg_reg ? (~num_reg + 1'b1) : num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg <= '0;
        end
        else if (cmd.step)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            den_reg <= b_mag;
            rem_reg <= '0;
            if (div_zero)
            begin
                num_reg  <= DIV_ZERO_VALUE[DATA_WIDTH-1:0];
                neg_reg  <= 1'b0;
                code_reg <= STAT_DIV_ZERO;
            end
            else if (overflow)
            begin
                num_reg  <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
                neg_reg  <= 1'b0;
                code_reg <= STAT_OVERFLOW;
            end
            else
            begin
                num_reg  <= a_mag;
                neg_reg  <= a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
                code_reg <= STAT_OK;
            end
        end
        else if (cmd.step)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
        if (cmd.commit)
        begin
            quotient_reg <= result;
            status_reg   <= code_reg;
        end
    end

    assign quotient = quotient_reg;
    assign status   = status_reg;

endmodule

@@ sv/signed_integer_divider_core.sv @@
// Signed integer divider, quotient truncated toward zero, no remainder.
// Input channel: in_valid/in_ready carry a request of dividend and divisor.
// Output channel: out_valid/out_ready carry quotient and status
// (ok, divide by zero with quotient 80085, or overflow saturated to the
// largest positive value for the most negative dividend over minus one).
// One request is worked at a time. For a regular division the accepting
// edge registers the operand magnitudes, the restoring shift-subtract loop
// then forms the quotient at one quotient bit per cycle, and a commit step
// applies the sign into the output register and raises out_valid. Divide
// by zero and overflow skip the loop and go straight to the commit. A new
// request is taken only after the previous result has been committed.
// in_ready is high whenever the controller is idle, so the next request is
// taken while an earlier result still waits in the output register. If the
// receiver stalls, the finished quotient waits in the datapath until the
// output register frees up; nothing is dropped.
// Reset clears the controller and out_valid; no request is in flight after it.
module signed_integer_divider_core #(
    parameter int DATA_WIDTH = sidc_pkg::DEF_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output sidc_pkg::status_t            status
);
    import sidc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sidc_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (status)
    );

endmodule
